// ----- rtl/aad_pkg.sv -----
// shared constants, register indexes and divider handshake structs
// for the area-average downscaler; no dependencies
package aad_pkg;

    localparam int MAX_TARGET_WIDTH = 4096;
    localparam int MAX_SOURCE_SIZE  = 4096;

    localparam int REG_W    = 13;
    localparam int COORD_W  = 12;
    localparam int ADDR_W   = $clog2(MAX_TARGET_WIDTH);
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 32;
    localparam int AREA_W   = 25;
    localparam int CNT_W    = $clog2(SUM_W);
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = CFG_IDX_W'(3);

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [AREA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [SUM_W-1:0]  quotient;
        logic [AREA_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- rtl/aad_pix_if.sv -----
// source pixel channel: valid/ready with rgb payload
// depends on aad_pkg
interface aad_pix_if;
    import aad_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

// ----- rtl/aad_res_if.sv -----
// result channel: valid/ready with averaged pixel and target coordinates
// depends on aad_pkg
interface aad_res_if;
    import aad_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_red;
    logic [PIX_W-1:0]   out_green;
    logic [PIX_W-1:0]   out_blue;
    logic [PIX_W-1:0]   out_alpha;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic               frame_end;
    modport source (output valid, out_red, out_green, out_blue, out_alpha,
                    out_column, out_row, frame_end, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha,
                  out_column, out_row, frame_end, output ready);
endinterface

// ----- rtl/area_average_downscaler.sv -----
// Area-average downscaler. Source pixels arrive in raster order and are
// summed per channel into a 4096-entry accumulator ram indexed by target
// column; when a box's last pixel arrives its sums are divided by the box
// area. An item that closes no box takes a ram read, then a write-back; an
// item that closes a box also waits for the 32-step bit-serial dividers and
// for the result register to be free. A write to one of the four geometry
// registers restarts the frame and runs the group-bound divisions; no pixel is
// taken until they finish. Writes to other indexes change nothing. An invalid
// configuration makes the block accept and drop every pixel.
module area_average_downscaler
(
    input  logic                          clk,
    input  logic                          rst_n,
    aad_pix_if.sink                       pix,
    aad_res_if.source                     res,
    input  logic                          cfg_we,
    input  logic [aad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aad_pkg::REG_W-1:0]     cfg_data
);
    import aad_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ACC   = 6'b000010,
        S_DIV   = 6'b000100,
        S_OUT   = 6'b001000,
        S_CFGGO = 6'b010000,
        S_CFG   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [REG_W-1:0] sw_reg, sh_reg, tw_reg, th_reg;
    logic [REG_W-1:0] col_q_reg, col_r_reg, row_q_reg, row_r_reg;

    logic [COORD_W-1:0] src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [COORD_W-1:0] tcol_reg, tcol_next, trow_reg, trow_next;
    logic [REG_W-1:0]   cgs_reg, cgs_next, cge_reg, cge_next, crem_reg, crem_next;
    logic [REG_W-1:0]   rgs_reg, rgs_next, rge_reg, rge_next, rrem_reg, rrem_next;

    logic cfg_ok, accept, cfg_done, cfg_hit;
    logic [REG_W-1:0] col_inc, row_inc;
    logic [REG_W:0]   ct, rt;
    logic [REG_W-1:0] cge_adv, crem_adv, rge_adv, rrem_adv;

    // latched item
    logic [PIX_W-1:0]   r_reg, g_reg, b_reg;
    logic               first_reg, last_reg, fend_reg;
    logic [COORD_W-1:0] ocol_reg, orow_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [2*REG_W-1:0] area_full;

    // accumulator ram
    logic                 ram_we;
    logic [3*SUM_W-1:0]   ram_wdata, ram_rdata;
    logic [SUM_W-1:0]     sum_r, sum_g, sum_b;

    div_req_t req_r, req_g, req_b;
    div_rsp_t rsp_r, rsp_g, rsp_b;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_r_reg, out_g_reg, out_b_reg;
    logic [COORD_W-1:0] out_col_reg, out_row_reg;
    logic               out_fend_reg;

    assign cfg_ok = sw_reg != '0 && sh_reg != '0 && tw_reg != '0 && th_reg != '0
                    && sw_reg <= REG_W'(MAX_SOURCE_SIZE)
                    && sh_reg <= REG_W'(MAX_SOURCE_SIZE)
                    && tw_reg <= sw_reg && th_reg <= sh_reg
                    && tw_reg <= REG_W'(MAX_TARGET_WIDTH);

    // only the geometry registers restart the frame
    assign cfg_hit   = cfg_we && cfg_index <= REG_TARGET_HEIGHT;
    assign pix.ready = state_reg == S_IDLE && !cfg_we;
    assign accept    = pix.valid && pix.ready;
    assign cfg_done  = state_reg == S_CFG && !rsp_r.busy;

    // group bound stepping
    always_comb
    begin
        col_inc  = {1'b0, src_col_reg} + REG_W'(1);
        row_inc  = {1'b0, src_row_reg} + REG_W'(1);
        ct       = {1'b0, crem_reg} + {1'b0, col_r_reg};
        rt       = {1'b0, rrem_reg} + {1'b0, row_r_reg};
        cge_adv  = cge_reg + col_q_reg + REG_W'(ct >= {1'b0, tw_reg});
        crem_adv = (ct >= {1'b0, tw_reg}) ? REG_W'(ct - {1'b0, tw_reg}) : ct[REG_W-1:0];
        rge_adv  = rge_reg + row_q_reg + REG_W'(rt >= {1'b0, th_reg});
        rrem_adv = (rt >= {1'b0, th_reg}) ? REG_W'(rt - {1'b0, th_reg}) : rt[REG_W-1:0];

        src_col_next = src_col_reg;
        tcol_next    = tcol_reg;
        cgs_next     = cgs_reg;
        cge_next     = cge_reg;
        crem_next    = crem_reg;
        src_row_next = src_row_reg;
        trow_next    = trow_reg;
        rgs_next     = rgs_reg;
        rge_next     = rge_reg;
        rrem_next    = rrem_reg;

        if (cfg_done)
        begin
            src_col_next = '0;
            tcol_next    = '0;
            cgs_next     = '0;
            cge_next     = rsp_r.quotient[REG_W-1:0];
            crem_next    = rsp_r.remainder[REG_W-1:0];
            src_row_next = '0;
            trow_next    = '0;
            rgs_next     = '0;
            rge_next     = rsp_g.quotient[REG_W-1:0];
            rrem_next    = rsp_g.remainder[REG_W-1:0];
        end
        else if (accept && cfg_ok)
        begin
            if (col_inc >= sw_reg)
            begin
                src_col_next = '0;
                tcol_next    = '0;
                cgs_next     = '0;
                cge_next     = col_q_reg;
                crem_next    = col_r_reg;
                if (row_inc >= sh_reg)
                begin
                    src_row_next = '0;
                    trow_next    = '0;
                    rgs_next     = '0;
                    rge_next     = row_q_reg;
                    rrem_next    = row_r_reg;
                end
                else
                begin
                    src_row_next = row_inc[COORD_W-1:0];
                    if (row_inc >= rge_reg)
                    begin
                        rgs_next  = rge_reg;
                        rge_next  = rge_adv;
                        rrem_next = rrem_adv;
                        trow_next = trow_reg + COORD_W'(1);
                    end
                end
            end
            else
            begin
                src_col_next = col_inc[COORD_W-1:0];
                if (col_inc >= cge_reg)
                begin
                    cgs_next  = cge_reg;
                    cge_next  = cge_adv;
                    crem_next = crem_adv;
                    tcol_next = tcol_reg + COORD_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && cfg_ok) state_next = S_ACC;
            S_ACC:   state_next = last_reg ? S_DIV : S_IDLE;
            S_DIV:   if (!rsp_r.busy) state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || res.ready) state_next = S_IDLE;
            S_CFGGO: state_next = S_CFG;
            S_CFG:   if (!rsp_r.busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (cfg_hit)
        begin
            state_next = S_CFGGO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sw_reg      <= REG_W'(1);
            sh_reg      <= REG_W'(1);
            tw_reg      <= REG_W'(1);
            th_reg      <= REG_W'(1);
            col_q_reg   <= REG_W'(1);
            col_r_reg   <= '0;
            row_q_reg   <= REG_W'(1);
            row_r_reg   <= '0;
            src_col_reg <= '0;
            tcol_reg    <= '0;
            cgs_reg     <= '0;
            cge_reg     <= REG_W'(1);
            crem_reg    <= '0;
            src_row_reg <= '0;
            trow_reg    <= '0;
            rgs_reg     <= '0;
            rge_reg     <= REG_W'(1);
            rrem_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            src_col_reg <= src_col_next;
            tcol_reg    <= tcol_next;
            cgs_reg     <= cgs_next;
            cge_reg     <= cge_next;
            crem_reg    <= crem_next;
            src_row_reg <= src_row_next;
            trow_reg    <= trow_next;
            rgs_reg     <= rgs_next;
            rge_reg     <= rge_next;
            rrem_reg    <= rrem_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                    REG_SOURCE_HEIGHT: sh_reg <= cfg_data;
                    REG_TARGET_WIDTH:  tw_reg <= cfg_data;
                    REG_TARGET_HEIGHT: th_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cfg_done)
            begin
                col_q_reg <= rsp_r.quotient[REG_W-1:0];
                col_r_reg <= rsp_r.remainder[REG_W-1:0];
                row_q_reg <= rsp_g.quotient[REG_W-1:0];
                row_r_reg <= rsp_g.remainder[REG_W-1:0];
            end
            if (state_reg == S_OUT && (!out_valid_reg || res.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign area_full = (cge_reg - cgs_reg) * (rge_reg - rgs_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg     <= pix.in_red;
            g_reg     <= pix.in_green;
            b_reg     <= pix.in_blue;
            first_reg <= src_row_reg == rgs_reg[COORD_W-1:0] && rgs_reg[REG_W-1] == 1'b0
                         && src_col_reg == cgs_reg[COORD_W-1:0] && cgs_reg[REG_W-1] == 1'b0;
            last_reg  <= col_inc == cge_reg && row_inc == rge_reg;
            ocol_reg  <= tcol_reg;
            orow_reg  <= trow_reg;
            fend_reg  <= {1'b0, tcol_reg} + REG_W'(1) == tw_reg
                         && {1'b0, trow_reg} + REG_W'(1) == th_reg;
            area_reg  <= (area_full == '0) ? AREA_W'(1) : area_full[AREA_W-1:0];
        end
        if (state_reg == S_OUT && (!out_valid_reg || res.ready))
        begin
            out_r_reg    <= rsp_r.quotient[PIX_W-1:0];
            out_g_reg    <= rsp_g.quotient[PIX_W-1:0];
            out_b_reg    <= rsp_b.quotient[PIX_W-1:0];
            out_col_reg  <= ocol_reg;
            out_row_reg  <= orow_reg;
            out_fend_reg <= fend_reg;
        end
    end

    // first pixel of a box overwrites the stale sum
    always_comb
    begin
        sum_r = first_reg ? SUM_W'(r_reg) : ram_rdata[SUM_W-1:0] + SUM_W'(r_reg);
        sum_g = first_reg ? SUM_W'(g_reg) : ram_rdata[2*SUM_W-1:SUM_W] + SUM_W'(g_reg);
        sum_b = first_reg ? SUM_W'(b_reg) : ram_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(b_reg);
    end

    assign ram_we    = state_reg == S_ACC;
    assign ram_wdata = {sum_b, sum_g, sum_r};

    aad_ram #(
        .WIDTH (3 * SUM_W),
        .DEPTH (MAX_TARGET_WIDTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (state_reg == S_ACC ? ocol_reg[ADDR_W-1:0] : tcol_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // lanes r and g also divide the group bounds after a register write
    always_comb
    begin
        req_r.start    = (state_reg == S_ACC && last_reg) || state_reg == S_CFGGO;
        req_g.start    = req_r.start;
        req_b.start    = req_r.start;
        req_r.dividend = (state_reg == S_CFGGO) ? SUM_W'(sw_reg) : sum_r;
        req_g.dividend = (state_reg == S_CFGGO) ? SUM_W'(sh_reg) : sum_g;
        req_b.dividend = sum_b;
        req_r.divisor  = (state_reg == S_CFGGO) ? AREA_W'(tw_reg) : area_reg;
        req_g.divisor  = (state_reg == S_CFGGO) ? AREA_W'(th_reg) : area_reg;
        req_b.divisor  = area_reg;
    end

    aad_div u_div_r (.clk(clk), .rst_n(rst_n), .req(req_r), .rsp(rsp_r));
    aad_div u_div_g (.clk(clk), .rst_n(rst_n), .req(req_g), .rsp(rsp_g));
    aad_div u_div_b (.clk(clk), .rst_n(rst_n), .req(req_b), .rsp(rsp_b));

    assign res.valid      = out_valid_reg;
    assign res.out_red    = out_r_reg;
    assign res.out_green  = out_g_reg;
    assign res.out_blue   = out_b_reg;
    assign res.out_alpha  = '0;
    assign res.out_column = out_col_reg;
    assign res.out_row    = out_row_reg;
    assign res.frame_end  = out_fend_reg;

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !rsp_r.busy)
        else $error("divider busy while idle");
    a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC && !$past(cfg_we) |-> $past(accept))
        else $error("write-back without a transaction");
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_r.busy == rsp_g.busy && rsp_g.busy == rsp_b.busy)
        else $error("divider lanes out of step");
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result loaded outside output state");
endmodule

// ----- rtl/aad_ram.sv -----
// generic single-port synchronous ram with registered read
// no dependencies
module aad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/aad_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on aad_pkg
module aad_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  aad_pkg::div_req_t req,
    output aad_pkg::div_rsp_t rsp
);
    import aad_pkg::*;

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [AREA_W-1:0] rem_reg;
    logic [AREA_W-1:0] dvs_reg;
    logic [AREA_W:0]   shifted;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? AREA_W'(shifted - {1'b0, dvs_reg}) : shifted[AREA_W-1:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    a_bounded_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CNT_W'(SUM_W - 1))
        else $error("divider step count overran");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg && cnt_reg == '0)
        else $error("divider did not start");
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(cnt_reg) == CNT_W'(SUM_W - 1))
        else $error("divider finished early");
endmodule
